// ----- rtl/turtle_plotter_bitmap_defines.svh -----
// Assertion macros for the turtle plotter bitmap block.
`ifndef TURTLE_PLOTTER_BITMAP_DEFINES_SVH
`define TURTLE_PLOTTER_BITMAP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TPB_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tpb assertion failed");
`define TPB_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tpb assertion failed");
`else
`define TPB_ASSERT_SAME(name, clk, rst, pre, post)
`define TPB_ASSERT_NEXT(name, clk, rst, pre, post)
`endif

`endif

// ----- rtl/tpb_pkg.sv -----
// Types and constants shared by the turtle plotter bitmap modules.
package tpb_pkg;

   localparam int KIND_W = 3;
   localparam int DIST_W = 8;
   localparam int POS_W  = 6;
   localparam int ROW_W  = 64;

   localparam logic [KIND_W-1:0] KIND_PEN_UP   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_PEN_DOWN = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RIGHT    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LEFT     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FORWARD  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READOUT  = 3'd5;

   localparam logic [1:0] HEAD_EAST = 2'd1;

   typedef struct packed {
      logic             rd_en;
      logic [POS_W-1:0] rd_addr;
      logic             wr_en;
      logic [POS_W-1:0] wr_addr;
      logic [ROW_W-1:0] wr_data;
   } mem_ctrl_type;

endpackage

// ----- rtl/tpb_row_mem.sv -----
// Bitmap row memory with per-row valid bits cleared at reset.
module tpb_row_mem #(
   parameter int GRID_SIZE = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tpb_pkg::mem_ctrl_type      ctrl,
   output logic [tpb_pkg::ROW_W-1:0]  rd_word
);

   localparam int IDX_W = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;

   logic [tpb_pkg::ROW_W-1:0] row_mem_ff [GRID_SIZE];
   logic [tpb_pkg::ROW_W-1:0] rd_data_ff;
   logic [GRID_SIZE-1:0]      valid_ff;
   logic                      rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         row_mem_ff[ctrl.wr_addr[IDX_W-1:0]] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= row_mem_ff[ctrl.rd_addr[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctrl.wr_en) begin
            valid_ff[ctrl.wr_addr[IDX_W-1:0]] <= 1'b1;
         end
         if (ctrl.rd_en) begin
            rd_valid_ff <= valid_ff[ctrl.rd_addr[IDX_W-1:0]];
         end
      end
   end

   // A row never written since reset reads blank.
   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/tpb_move_unit.sv -----
// Shared move unit: advance a position by a distance, clamped to the grid.
module tpb_move_unit #(
   parameter int GRID_SIZE = 64
) (
   input  logic [tpb_pkg::POS_W-1:0]  pos,
   input  logic [tpb_pkg::DIST_W-1:0] span,
   input  logic                       up,
   output logic [tpb_pkg::POS_W-1:0]  res
);

   localparam int SUM_W = tpb_pkg::DIST_W + 1;
   localparam logic [SUM_W-1:0] LAST_SUM = SUM_W'(GRID_SIZE - 1);

   logic [SUM_W-1:0] pos_ext;
   logic [SUM_W-1:0] span_ext;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] diff;

   always_comb begin
      pos_ext  = SUM_W'(pos);
      span_ext = SUM_W'(span);
      sum      = pos_ext + span_ext;
      diff     = pos_ext - span_ext;
      if (up) begin
         res = (span_ext >= pos_ext) ? '0 : diff[tpb_pkg::POS_W-1:0];
      end else begin
         res = (sum > LAST_SUM) ? LAST_SUM[tpb_pkg::POS_W-1:0] : sum[tpb_pkg::POS_W-1:0];
      end
   end

endmodule

// ----- rtl/turtle_plotter_bitmap.sv -----
// Turtle plotter command interpreter over a square one-bit bitmap.
//
// Commands arrive on the req_ channel (req_kind, req_distance) and are taken
// one at a time; req_ready is high only while the sequencer is idle.
// Pen and turn commands finish in the cycle they are accepted. A forward
// move first plans the clamped end point in S_PLAN, then marks one cell
// per cycle in S_DRAW with the pen down; with the pen up or when blocked
// it returns to idle after the plan. Cells are marked by the shared move
// unit stepping the position one cell a cycle against a row memory with
// one read and one write port; horizontal runs collect in a row buffer
// and write once. A readout emits GRID_SIZE beats on the rsp_ channel,
// one row a cycle from the memory read port while rsp_ready does not
// stall it; the final beat has rsp_last_row set. The result sits in an
// output register, so a stalled rsp_ready only holds the row scan, and a
// new command may be accepted while the last row still waits to be taken.
// Reset puts the turtle at row 0, column 0, facing east, pen up, and clears
// the per-row valid bits so the bitmap reads blank at once.
module turtle_plotter_bitmap #(
   parameter int GRID_SIZE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tpb_pkg::KIND_W-1:0]  req_kind,
   input  logic [tpb_pkg::DIST_W-1:0]  req_distance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tpb_pkg::POS_W-1:0]   rsp_row_index,
   output logic [tpb_pkg::ROW_W-1:0]   rsp_row_bits,
   output logic                        rsp_last_row
);

`include "turtle_plotter_bitmap_defines.svh"

   localparam logic [tpb_pkg::POS_W-1:0] LAST_POS = tpb_pkg::POS_W'(GRID_SIZE - 1);

   typedef enum logic [1:0] {S_IDLE, S_PLAN, S_DRAW, S_READ} state_type;

   state_type                  state_ff, state_in;
   logic [tpb_pkg::POS_W-1:0]  row_pos_ff, row_pos_in;
   logic [tpb_pkg::POS_W-1:0]  col_pos_ff, col_pos_in;
   logic [1:0]                 heading_ff, heading_in;
   logic                       pen_up_ff, pen_up_in;
   logic [tpb_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [tpb_pkg::POS_W-1:0]  tgt_ff, tgt_in;
   logic [tpb_pkg::ROW_W-1:0]  buf_ff, buf_in;
   logic                       first_ff, first_in;
   logic [tpb_pkg::POS_W-1:0]  scan_row_ff, scan_row_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tpb_pkg::POS_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [tpb_pkg::ROW_W-1:0]  rsp_bits_ff, rsp_bits_in;
   logic                       rsp_last_ff, rsp_last_in;

   tpb_pkg::mem_ctrl_type      mem_ctrl;
   logic [tpb_pkg::ROW_W-1:0]  rd_word;

   logic                       axis_col;
   logic                       move_up;
   logic [tpb_pkg::POS_W-1:0]  mv_pos;
   logic [tpb_pkg::DIST_W-1:0] mv_dist;
   logic [tpb_pkg::POS_W-1:0]  mv_res;
   logic [tpb_pkg::ROW_W-1:0]  cur_word;
   logic [tpb_pkg::ROW_W-1:0]  new_word;
   logic                       req_fire;
   logic                       out_free;
   logic                       draw_done;

   tpb_row_mem #(.GRID_SIZE(GRID_SIZE)) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mem_ctrl),
      .rd_word (rd_word)
   );

   tpb_move_unit #(.GRID_SIZE(GRID_SIZE)) u_move_unit (
      .pos  (mv_pos),
      .span (mv_dist),
      .up   (move_up),
      .res  (mv_res)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // East and west move along the column; north and west decrease.
   assign axis_col = heading_ff[0];
   assign move_up  = ~(heading_ff[1] ^ heading_ff[0]);
   assign mv_pos   = axis_col ? col_pos_ff : row_pos_ff;
   assign mv_dist  = (state_ff == S_DRAW) ? tpb_pkg::DIST_W'(1) : dist_ff;

   assign cur_word  = first_ff ? rd_word : buf_ff;
   assign new_word  = cur_word | (tpb_pkg::ROW_W'(1) << col_pos_ff);
   assign draw_done = (mv_res == tgt_ff);

   always_comb begin
      state_in     = state_ff;
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      heading_in   = heading_ff;
      pen_up_in    = pen_up_ff;
      dist_in      = dist_ff;
      tgt_in       = tgt_ff;
      buf_in       = buf_ff;
      first_in     = first_ff;
      scan_row_in  = scan_row_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_last_in  = rsp_last_ff;
      mem_ctrl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  tpb_pkg::KIND_PEN_UP:   pen_up_in  = 1'b1;
                  tpb_pkg::KIND_PEN_DOWN: pen_up_in  = 1'b0;
                  tpb_pkg::KIND_RIGHT:    heading_in = heading_ff + 2'd1;
                  tpb_pkg::KIND_LEFT:     heading_in = heading_ff - 2'd1;
                  tpb_pkg::KIND_FORWARD: begin
                     dist_in  = req_distance;
                     state_in = S_PLAN;
                  end
                  tpb_pkg::KIND_READOUT: begin
                     mem_ctrl.rd_en   = 1'b1;
                     mem_ctrl.rd_addr = '0;
                     scan_row_in      = '0;
                     state_in         = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_PLAN: begin
            if (pen_up_ff || (mv_res == mv_pos)) begin
               if (axis_col) begin
                  col_pos_in = mv_res;
               end else begin
                  row_pos_in = mv_res;
               end
               state_in = S_IDLE;
            end else begin
               tgt_in           = mv_res;
               first_in         = 1'b1;
               mem_ctrl.rd_en   = 1'b1;
               mem_ctrl.rd_addr = row_pos_ff;
               state_in         = S_DRAW;
            end
         end
         S_DRAW: begin
            // Write on every row change and at the end; otherwise keep the row buffered.
            if (!axis_col || draw_done) begin
               mem_ctrl.wr_en   = 1'b1;
               mem_ctrl.wr_addr = row_pos_ff;
               mem_ctrl.wr_data = new_word;
               first_in         = 1'b1;
            end else begin
               buf_in   = new_word;
               first_in = 1'b0;
            end
            if (axis_col) begin
               col_pos_in = mv_res;
            end else begin
               row_pos_in       = mv_res;
               mem_ctrl.rd_en   = !draw_done;
               mem_ctrl.rd_addr = mv_res;
            end
            if (draw_done) begin
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = scan_row_ff;
               rsp_bits_in  = rd_word;
               rsp_last_in  = (scan_row_ff == LAST_POS);
               if (scan_row_ff == LAST_POS) begin
                  state_in = S_IDLE;
               end else begin
                  mem_ctrl.rd_en   = 1'b1;
                  mem_ctrl.rd_addr = scan_row_ff + tpb_pkg::POS_W'(1);
                  scan_row_in      = scan_row_ff + tpb_pkg::POS_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         heading_ff   <= tpb_pkg::HEAD_EAST;
         pen_up_ff    <= 1'b1;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         heading_ff   <= heading_in;
         pen_up_ff    <= pen_up_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dist_ff     <= dist_in;
      tgt_ff      <= tgt_in;
      buf_ff      <= buf_in;
      scan_row_ff <= scan_row_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_row_bits  = rsp_bits_ff;
   assign rsp_last_row  = rsp_last_ff;

   `TPB_ASSERT_SAME(a_pos_in_grid, clock, reset, 1'b1, (row_pos_ff <= LAST_POS) && (col_pos_ff <= LAST_POS))
   `TPB_ASSERT_SAME(a_scan_open, clock, reset, rsp_valid && rsp_ready && !rsp_last_row, state_ff == S_READ)
   `TPB_ASSERT_SAME(a_buffer_horiz, clock, reset, (state_ff == S_DRAW) && !first_ff, heading_ff[0])
   `TPB_ASSERT_NEXT(a_draw_ends, clock, reset, (state_ff == S_DRAW) && draw_done, state_ff == S_IDLE)

endmodule
